@@ rtl/bif_pkg.sv @@
// ----------------------------------------------------------------------------
// bif_pkg
// Shared types and constants of the bytecode instruction framer.
// ----------------------------------------------------------------------------
package bif_pkg;

  // Largest capture count accepted in a CLOSURE instruction
  localparam int unsigned MaxCaptures = 255;

  localparam logic [7:0] OP_CLOSURE = 8'h54;

  // Positions of the little-endian capture count within a CLOSURE
  localparam int unsigned CAPT_FIRST_POS = 5;
  localparam int unsigned CAPT_LAST_POS  = 8;

  // Bytes still to come and position: longest instruction is 9 + 5 * max
  localparam int unsigned LEFT_W = $clog2(9 + 5 * MaxCaptures);
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned POS_W  = (LEFT_W > IDX_W) ? LEFT_W : IDX_W;

  localparam int unsigned TOTAL_W = 32;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_BAD_COUNT = 3'd3,
    ST_HALTED    = 3'd4
  } status_e;

  // Length class of an opcode
  typedef enum logic [1:0] {
    LEN_NONE = 2'd0,
    LEN_1    = 2'd1,
    LEN_5    = 2'd2,
    LEN_9    = 2'd3
  } len_e;

  typedef struct packed {
    len_e len;
    logic closure;
  } len_info_t;

endpackage

@@ rtl/bytecode_instruction_framer_top.sv @@
// ----------------------------------------------------------------------------
// bytecode_instruction_framer_top
// Marks instruction boundaries in a bytecode stream, one result beat per byte.
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after its byte is taken.
// Throughput: one byte per cycle while results drain; the frame state updates in a single pass.
// A byte is taken while the result register is empty or being drained.
// Reset (rst_ni low, asynchronous): between instructions, not halted,
// instruction total cleared, result register empty. No clearing pass.
module bytecode_instruction_framer_top
  import bif_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] code_byte
  input  logic        s_axis_tlast_i,   // stream_end
  // Result beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [7:0] opcode, [8] instr_start,
                                        // [19:9] byte_index, [22:20] status,
                                        // [54:23] instr_total, [55] zero
  output logic        m_axis_tlast_o    // instr_end
);

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic               in_instr_q, in_instr_d;
  logic               halted_q, halted_d;
  logic [7:0]         cur_op_q, cur_op_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  // Low three bytes of the capture count; the top byte arrives on byte 8
  logic [23:0]        capt_q, capt_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // Result register
  logic               out_valid_q;
  logic [7:0]         out_op_q, out_op_d;
  logic               out_start_q, out_start_d;
  logic               out_end_q, out_end_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  status_e            out_status_q, out_status_d;

  logic       accept;
  logic [7:0] in_byte;
  logic       in_last;
  len_info_t  len_info;

  logic        cur_closure;
  logic [31:0] capt_full;
  logic [LEFT_W-1:0] left_dec;
  logic [LEFT_W-1:0] capt_lo;
  logic        count_done;

  assign in_byte = s_axis_tdata_i;
  assign in_last = s_axis_tlast_i;

  // Result register frees up the same cycle it is drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  bif_len_dec u_len_dec (
    .opcode_i (in_byte),
    .info_o   (len_info)
  );

  assign cur_closure = (cur_op_q == OP_CLOSURE);
  assign capt_full   = {in_byte, capt_q};
  assign capt_lo     = capt_full[LEFT_W-1:0];
  assign left_dec    = (left_q != '0) ? left_q - LEFT_W'(1) : left_q;

  always_comb begin
    in_instr_d   = in_instr_q;
    halted_d     = halted_q;
    cur_op_d     = cur_op_q;
    left_d       = left_q;
    pos_d        = pos_q;
    capt_d       = capt_q;
    count_done   = 1'b0;

    out_op_d     = '0;
    out_start_d  = 1'b0;
    out_end_d    = 1'b0;
    out_idx_d    = '0;
    out_status_d = ST_OK;

    if (halted_q) begin
      out_status_d = ST_HALTED;
    end else if (!in_instr_q) begin
      // Opcode byte
      out_op_d    = in_byte;
      out_start_d = 1'b1;
      case (len_info.len)
        LEN_NONE: begin
          out_status_d = ST_INVALID;
          halted_d     = 1'b1;
        end
        LEN_1: begin
          out_end_d  = 1'b1;
          count_done = 1'b1;
        end
        default: begin
          in_instr_d = 1'b1;
          cur_op_d   = in_byte;
          left_d     = (len_info.len == LEN_5) ? LEFT_W'(4) : LEFT_W'(8);
          pos_d      = POS_W'(1);
          capt_d     = '0;
          if (in_last) out_status_d = ST_TRUNCATED;
        end
      endcase
    end else begin
      // Operand byte
      out_op_d  = cur_op_q;
      out_idx_d = pos_q[IDX_W-1:0];
      left_d    = left_dec;
      if (cur_closure) begin
        case (pos_q)
          POS_W'(CAPT_FIRST_POS):     capt_d[7:0]   = in_byte;
          POS_W'(CAPT_FIRST_POS + 1): capt_d[15:8]  = in_byte;
          POS_W'(CAPT_FIRST_POS + 2): capt_d[23:16] = in_byte;
          default: ;
        endcase
      end
      // Full count known on the last count byte
      if (cur_closure && pos_q == POS_W'(CAPT_LAST_POS)) begin
        if (capt_full > 32'(MaxCaptures)) begin
          out_status_d = ST_BAD_COUNT;
          halted_d     = 1'b1;
        end else begin
          left_d = (capt_lo << 2) + capt_lo;
        end
      end
      if (out_status_d == ST_OK) begin
        if (left_d == '0) begin
          out_end_d  = 1'b1;
          in_instr_d = 1'b0;
          pos_d      = '0;
          count_done = 1'b1;
        end else begin
          pos_d = pos_q + POS_W'(1);
          if (in_last) out_status_d = ST_TRUNCATED;
        end
      end
    end

    // End of stream drops any frame in progress and any error
    if (in_last) begin
      in_instr_d = 1'b0;
      halted_d   = 1'b0;
      cur_op_d   = '0;
      left_d     = '0;
      pos_d      = '0;
      capt_d     = '0;
    end

    // Saturating instruction total
    total_d = total_q;
    if (count_done && total_q != '1) total_d = total_q + TOTAL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_instr_q <= 1'b0;
      halted_q   <= 1'b0;
      cur_op_q   <= '0;
      left_q     <= '0;
      pos_q      <= '0;
      capt_q     <= '0;
      total_q    <= '0;
    end else if (accept) begin
      in_instr_q <= in_instr_d;
      halted_q   <= halted_d;
      cur_op_q   <= cur_op_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      capt_q     <= capt_d;
      total_q    <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_op_q     <= out_op_d;
      out_start_q  <= out_start_d;
      out_end_q    <= out_end_d;
      out_idx_q    <= out_idx_d;
      out_status_q <= out_status_d;
    end
  end

  // total_q already holds the count after the byte in the result register
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_end_q;
  assign m_axis_tdata_o  = {1'b0, total_q, out_status_q, out_idx_q, out_start_q, out_op_q};

endmodule

@@ rtl/bif_len_dec.sv @@
// ----------------------------------------------------------------------------
// bif_len_dec
// Opcode length decoder: maps an opcode byte to its length class.
// ----------------------------------------------------------------------------
module bif_len_dec
  import bif_pkg::*;
(
  input  logic [7:0] opcode_i,
  output len_info_t  info_o
);

  logic [3:0] hi;
  logic [3:0] lo;

  assign hi = opcode_i[7:4];
  assign lo = opcode_i[3:0];

  always_comb begin
    info_o.len     = LEN_NONE;
    info_o.closure = (opcode_i == OP_CLOSURE);
    case (hi)
      4'h0, 4'h6, 4'hF: info_o.len = LEN_1;
      4'h1: begin
        if (lo inside {4'h0, 4'h1, 4'h5})           info_o.len = LEN_5;
        else if (lo == 4'h2)                        info_o.len = LEN_9;
        else if (lo inside {[4'h3:4'hB]})           info_o.len = LEN_1;
        else                                        info_o.len = LEN_NONE;
      end
      4'h2, 4'h3, 4'h4: info_o.len = LEN_5;
      4'h5: begin
        // CLOSURE is 9 bytes before its captures
        if (lo inside {4'h0, 4'h1, 4'h5, 4'h8, 4'hA}) info_o.len = LEN_5;
        else if (lo inside {4'h2, 4'h3, 4'h4, 4'h6, 4'h7, 4'h9})
                                                     info_o.len = LEN_9;
        else                                         info_o.len = LEN_NONE;
      end
      4'h7: begin
        if (lo inside {[4'h0:4'h3]})  info_o.len = LEN_1;
        else if (lo == 4'h4)          info_o.len = LEN_5;
        else                          info_o.len = LEN_NONE;
      end
      default: info_o.len = LEN_NONE;
    endcase
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bytecode instruction framer. Directed corner
// streams, then random frames of mostly well-formed instructions with some
// invalid opcodes, bad capture counts and truncated frames. Every result beat
// is compared with a frame tracker that follows the instruction boundaries.
// ----------------------------------------------------------------------------
module tb_top;
  import bif_pkg::*;

  // Instruction lengths and CLOSURE layout
  localparam int unsigned LEN_SHORT   = 1;
  localparam int unsigned LEN_MID     = 5;
  localparam int unsigned LEN_LONG    = 9;
  localparam int unsigned CAPT_STRIDE = 5;

  // Opcodes used by the directed streams
  localparam logic [7:0] OP_ONE_LO = 8'h00;  // one-byte, bottom of range
  localparam logic [7:0] OP_ONE_HI = 8'hFF;  // one-byte, top of range
  localparam logic [7:0] OP_BAD    = 8'h1C;  // not a valid opcode
  localparam logic [7:0] OP_FIVE_A = 8'h20;  // five-byte
  localparam logic [7:0] OP_FIVE_B = 8'h30;  // five-byte

  // Opcode classes for the random picker
  localparam int unsigned PICK_BAD  = 0;
  localparam int unsigned PICK_ANY  = 1;
  localparam int unsigned PICK_LONG = 2;

  localparam int unsigned RAND_BYTES  = 900;
  localparam int unsigned BIG_KEEP    = 40;    // capture bytes sent of the limit CLOSURE
  localparam int unsigned IDLE_PCT    = 11;
  localparam int unsigned HOLD_AT     = 200;   // result beats before the long hold-off
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CALM_LO     = 550;   // result beats with no receiver stalls
  localparam int unsigned CALM_HI     = 750;
  localparam int unsigned QUIET_LO    = 300;   // input bytes with no sender gaps
  localparam int unsigned QUIET_HI    = 500;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  opcode;
    logic        is_start;
    logic        is_end;
    logic [10:0] idx;
    status_e     status;
    logic [31:0] total;
  } frame_mark_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [55:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  code_beat_t  stim_q[$];
  int unsigned bytes_sent;
  int unsigned cycle_cnt;

  // Length from the opcode nibbles; 0 for an invalid opcode, CLOSURE reads as 9
  function automatic int unsigned op_len(logic [7:0] op);
    logic [3:0] lo;
    lo = op[3:0];
    case (op[7:4])
      4'h0, 4'h6, 4'hF: return LEN_SHORT;
      4'h2, 4'h3, 4'h4: return LEN_MID;
      4'h1: begin
        case (lo)
          4'h0, 4'h1, 4'h5: return LEN_MID;
          4'h2: return LEN_LONG;
          4'h3, 4'h4, 4'h6, 4'h7, 4'h8, 4'h9, 4'hA, 4'hB: return LEN_SHORT;
          default: return 0;
        endcase
      end
      4'h5: begin
        case (lo)
          4'h0, 4'h1, 4'h5, 4'h8, 4'hA: return LEN_MID;
          4'h2, 4'h3, 4'h4, 4'h6, 4'h7, 4'h9: return LEN_LONG;
          default: return 0;
        endcase
      end
      4'h7: begin
        if (lo <= 4'h3) return LEN_SHORT;
        if (lo == 4'h4) return LEN_MID;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  // Follows the framer byte by byte and keeps the result beats still owed
  class frame_tracker;
    bit          in_instr;
    bit          halted;
    int unsigned left;
    int unsigned pos;
    logic [7:0]  cur_op;
    logic [31:0] capt;
    logic [31:0] done_cnt;
    frame_mark_t marks_q[$];

    int unsigned mismatches;
    int unsigned beats;
    int unsigned bytes_in;
    int unsigned closures;
    int unsigned st_cnt[5];

    function new();
      clear_frame();
      done_cnt = '0;
    endfunction

    function void clear_frame();
      in_instr = 1'b0;
      halted   = 1'b0;
      left     = 0;
      pos      = 0;
      cur_op   = '0;
      capt     = '0;
    endfunction

    function int unsigned pending();
      return marks_q.size();
    endfunction

    // Accepted input beat: work out the result it owes
    function void note_byte(logic [7:0] b, logic last);
      frame_mark_t m;
      int unsigned len;
      m = '0;
      m.status = ST_OK;
      bytes_in++;
      if (halted) begin
        m.status = ST_HALTED;
      end else if (!in_instr) begin
        len = op_len(b);
        m.opcode   = b;
        m.is_start = 1'b1;
        if (len == 0) begin
          m.status = ST_INVALID;
          halted   = 1'b1;
        end else if (len == LEN_SHORT) begin
          m.is_end = 1'b1;
          if (done_cnt != '1) done_cnt++;
        end else begin
          in_instr = 1'b1;
          cur_op   = b;
          left     = len - 1;
          pos      = 1;
          capt     = '0;
          if (last) m.status = ST_TRUNCATED;
        end
      end else begin
        m.opcode = cur_op;
        m.idx    = 11'(pos);
        if (cur_op == OP_CLOSURE && pos >= CAPT_FIRST_POS && pos <= CAPT_LAST_POS)
          capt |= 32'(b) << (8 * (pos - CAPT_FIRST_POS));
        if (left > 0) left--;
        if (cur_op == OP_CLOSURE && pos == CAPT_LAST_POS) begin
          if (capt > MaxCaptures) begin
            m.status = ST_BAD_COUNT;
            halted   = 1'b1;
          end else begin
            left = CAPT_STRIDE * capt;
          end
        end
        if (m.status == ST_OK) begin
          if (left == 0) begin
            m.is_end = 1'b1;
            in_instr = 1'b0;
            pos      = 0;
            if (cur_op == OP_CLOSURE) closures++;
            if (done_cnt != '1) done_cnt++;
          end else begin
            pos++;
            if (last) m.status = ST_TRUNCATED;
          end
        end
      end
      if (last) clear_frame();
      m.total = done_cnt;
      st_cnt[m.status]++;
      marks_q.push_back(m);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void same(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) report($sformatf("result %0d %s", beats, what), want, got);
    endfunction

    // Accepted result beat: compare against the oldest owed result
    function void check_beat(logic [55:0] data, logic last);
      frame_mark_t m;
      beats++;
      if (marks_q.size() == 0) begin
        report($sformatf("result %0d with nothing outstanding", beats), '0, data);
        return;
      end
      m = marks_q.pop_front();
      same("opcode",      m.opcode,   data[7:0]);
      same("instr_start", m.is_start, data[8]);
      same("byte_index",  m.idx,      data[19:9]);
      same("status",      m.status,   data[22:20]);
      same("instr_total", m.total,    data[54:23]);
      same("pad bit",     '0,         data[55]);
      same("instr_end",   m.is_end,   last);
    endfunction
  endclass

  frame_tracker tracker;

  bytecode_instruction_framer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  // Both handshakes are sampled at the edge, before any driver update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        tracker.note_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        tracker.check_beat(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, tracker.pending());
      $display("bytecode_instruction_framer_top regression: fail");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] b, logic last = 1'b0);
    code_beat_t cb;
    cb.code = b;
    cb.last = last;
    stim_q.push_back(cb);
  endfunction

  // Capture count, little-endian
  function automatic void push_count(logic [31:0] c);
    for (int k = 0; k < 4; k++) push_byte(c[8*k +: 8]);
  endfunction

  function automatic logic [7:0] pick_opcode(int unsigned want);
    logic [7:0] op;
    bit ok;
    do begin
      op = 8'($urandom_range(255));
      case (want)
        PICK_BAD: ok = (op_len(op) == 0);
        PICK_ANY: ok = (op_len(op) != 0);
        default:  ok = (op_len(op) > LEN_SHORT);
      endcase
    end while (!ok);
    return op;
  endfunction

  task automatic build_directed();
    push_byte(OP_ONE_LO);
    push_byte(OP_ONE_HI);
    // invalid opcode halts; the halt holds until the stream end
    push_byte(OP_BAD);
    push_byte(8'hAB);
    push_byte(OP_ONE_LO, 1'b1);
    // stream ends inside an instruction, then right on an opcode byte
    push_byte(OP_FIVE_A);
    push_byte(8'hFF, 1'b1);
    push_byte(OP_FIVE_B, 1'b1);
    // CLOSURE with no captures: nine bytes
    push_byte(OP_CLOSURE);
    push_byte(8'hA5); push_byte(8'h5A); push_byte(8'hFF); push_byte(8'h00);
    push_count(32'd0);
    // CLOSURE with a count that is negative as signed; bad count beats truncation
    push_byte(OP_CLOSURE);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
    push_count(32'h8000_0100);
    stim_q[stim_q.size()-1].last = 1'b1;
  endtask

  // Frames of instructions; an error or truncation closes the frame early
  task automatic build_random();
    int unsigned goal;
    int unsigned n_instr;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [31:0] cnt;
    logic [7:0]  op;
    bit          big_done;
    bit          stop;
    goal     = stim_q.size() + RAND_BYTES;
    big_done = 1'b0;
    while (stim_q.size() < goal) begin
      n_instr = $urandom_range(1, 12);
      stop    = 1'b0;
      for (int i = 0; i < n_instr && !stop; i++) begin
        kind = $urandom_range(99);
        if (kind < 82) begin
          if (!big_done && stim_q.size() > goal - RAND_BYTES / 2) begin
            // one CLOSURE at the capture limit, cut short by the stream end
            op       = OP_CLOSURE;
            cnt      = MaxCaptures;
            big_done = 1'b1;
            stop     = 1'b1;
          end else begin
            op  = ($urandom_range(9) == 0) ? OP_CLOSURE : pick_opcode(PICK_ANY);
            cnt = $urandom_range(3);
          end
          push_byte(op);
          if (op == OP_CLOSURE) begin
            for (int k = 1; k < CAPT_FIRST_POS; k++) push_byte(8'($urandom()));
            push_count(cnt);
            for (int k = 0; k < (stop ? BIG_KEEP : CAPT_STRIDE * cnt); k++)
              push_byte(8'($urandom()));
          end else begin
            len = op_len(op);
            for (int k = 1; k < len; k++) push_byte(8'($urandom()));
          end
        end else if (kind < 89) begin
          push_byte(pick_opcode(PICK_BAD));
          for (int k = $urandom_range(3); k > 0; k--) push_byte(8'($urandom()));
          stop = 1'b1;
        end else if (kind < 94) begin
          push_byte(OP_CLOSURE);
          for (int k = 1; k < CAPT_FIRST_POS; k++) push_byte(8'($urandom()));
          cnt = $urandom_range(1) ? 32'(MaxCaptures + 1)
                                  : $urandom_range(32'hFFFF_FFFF, MaxCaptures + 1);
          push_count(cnt);
          for (int k = $urandom_range(3); k > 0; k--) push_byte(8'($urandom()));
          stop = 1'b1;
        end else begin
          op  = pick_opcode(PICK_LONG);
          cut = $urandom_range(op_len(op) - 2);
          push_byte(op);
          for (int k = 0; k < cut; k++) push_byte(8'($urandom()));
          stop = 1'b1;
        end
      end
      stim_q[stim_q.size()-1].last = 1'b1;
    end
  endtask

  // Offers every queued byte; random gaps outside the quiet stretch
  task automatic drive_bytes();
    code_beat_t cb;
    while (stim_q.size() != 0) begin
      cb = stim_q.pop_front();
      if ((bytes_sent < QUIET_LO || bytes_sent >= QUIET_HI) &&
          $urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= cb.code;
      s_axis_tlast_i  <= cb.last;
      do @(posedge clk_i); while (!s_axis_tready_o);
      bytes_sent++;
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, one long hold-off, one calm stretch
  initial begin : result_sink
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && tracker.beats >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= (tracker.beats >= CALM_LO && tracker.beats < CALM_HI) ||
                           ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : main_seq
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    bytes_sent      = 0;
    cycle_cnt       = 0;
    tracker         = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    build_directed();
    drive_bytes();
    // sender holds back until every owed result is in
    wait_drained();
    build_random();
    drive_bytes();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d code bytes, %0d results, %0d instructions done, %0d closures",
             tracker.bytes_in, tracker.beats, tracker.done_cnt, tracker.closures);
    $display("invalid opcode %0d, truncated %0d, bad count %0d, halted bytes %0d",
             tracker.st_cnt[ST_INVALID], tracker.st_cnt[ST_TRUNCATED],
             tracker.st_cnt[ST_BAD_COUNT], tracker.st_cnt[ST_HALTED]);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("bytecode_instruction_framer_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d results outstanding",
               tracker.mismatches, tracker.pending());
      $display("bytecode_instruction_framer_top regression: fail");
    end
    $finish;
  end

endmodule
